### rtl/core/hgrp_pkg.sv
// Package for the HTTP GET request parser: word types, parser state and codes.
// Used by hgrp_step and http_get_request_parser; it depends on nothing else.
package hgrp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [3:0] METHOD_LEN  = 4'd3;
    localparam logic [3:0] PREFIX_LEN  = 4'd7;
    localparam logic [3:0] VERSION_LEN = 4'd8;

    typedef enum logic [1:0] {
        V_MORE = 2'd0,
        V_GET  = 2'd1,
        V_BAD  = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        F_METHOD  = 3'd0,
        F_GAP1    = 3'd1,
        F_URL     = 3'd2,
        F_GAP2    = 3'd3,
        F_VERSION = 3'd4
    } t_field;

    typedef enum logic [2:0] {
        U_IDLE       = 3'd0,
        U_PREFIX     = 3'd1,
        U_GOOD       = 3'd2,
        U_WAIT_SLASH = 3'd3,
        U_BAD        = 3'd4
    } t_url;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       conn_start;
    } t_in_word;

    typedef struct packed {
        logic [1:0] verdict;
        logic       in_headers;
    } t_out_word;

    typedef struct packed {
        logic       in_headers;
        t_verdict   verdict;
        logic       cr_pending;
        logic       line_empty;
        t_field     field;
        logic [3:0] match_pos;
        logic       match_ok;
        t_url       url;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        in_headers: 1'b0,
        verdict:    V_MORE,
        cr_pending: 1'b0,
        line_empty: 1'b1,
        field:      F_METHOD,
        match_pos:  4'd0,
        match_ok:   1'b1,
        url:        U_IDLE
    };

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] pos);
        case (pos)
            2'd0:    return 8'h67; // g
            2'd1:    return 8'h65; // e
            default: return 8'h74; // t
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h68; // h
            3'd1:    return 8'h74; // t
            3'd2:    return 8'h74; // t
            3'd3:    return 8'h70; // p
            3'd4:    return 8'h3A; // :
            default: return 8'h2F; // /
        endcase
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h48; // H
            3'd1:    return 8'h54; // T
            3'd2:    return 8'h54; // T
            3'd3:    return 8'h50; // P
            3'd4:    return 8'h2F; // /
            3'd5:    return 8'h31; // 1
            3'd6:    return 8'h2E; // .
            default: return 8'h31; // 1
        endcase
    endfunction

endpackage

### rtl/core/hgrp_step.sv
// Next-state logic of the request parser for one received word.
// Depends on hgrp_pkg for the state struct, codes and character tables.
module hgrp_step (
    input  hgrp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_conn_start,
    output hgrp_pkg::t_parse_state o_state
);
    import hgrp_pkg::*;

    t_parse_state s;
    t_parse_state n;
    logic         sep;
    logic [7:0]   lc;
    t_url         url_cur;
    logic [3:0]   url_pos;

    assign sep = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign lc  = to_lower(i_byte);

    always_comb begin
        s = i_conn_start ? STATE_RESET : i_state;
        n = s;
        url_cur = s.url;
        url_pos = s.match_pos;

        if (s.verdict == V_MORE) begin
            if (s.cr_pending) begin
                n.cr_pending = 1'b0;
                if (i_byte == CH_LF) begin
                    if (!s.in_headers) begin
                        if (s.match_ok && s.field == F_VERSION && s.match_pos == VERSION_LEN) begin
                            n.in_headers = 1'b1;
                        end else begin
                            n.verdict = V_BAD;
                        end
                    end else if (s.line_empty) begin
                        n.verdict = V_GET;
                    end
                    n.line_empty = 1'b1;
                    n.field      = F_METHOD;
                    n.match_pos  = 4'd0;
                    n.match_ok   = 1'b1;
                    n.url        = U_IDLE;
                end else begin
                    n.verdict = V_BAD;
                end
            end else if (i_byte == CH_CR) begin
                n.cr_pending = 1'b1;
            end else if (i_byte == CH_LF) begin
                n.verdict = V_BAD;
            end else begin
                n.line_empty = 1'b0;
                if (!s.in_headers) begin
                    case (s.field)
                        F_METHOD: begin
                            if (sep) begin
                                if (s.match_pos != METHOD_LEN) begin
                                    n.match_ok = 1'b0;
                                end
                                n.field     = F_GAP1;
                                n.match_pos = 4'd0;
                            end else if (s.match_pos < METHOD_LEN
                                         && lc == method_char(s.match_pos[1:0])) begin
                                n.match_pos = 4'(s.match_pos + 4'd1);
                            end else begin
                                n.match_ok = 1'b0;
                            end
                        end
                        F_GAP1, F_URL: begin
                            if (s.field == F_URL && sep) begin
                                if (s.url != U_GOOD) begin
                                    n.match_ok = 1'b0;
                                end
                                n.field     = F_GAP2;
                                n.match_pos = 4'd0;
                            end else if (!sep || s.field == F_URL) begin
                                // The first URL byte starts the prefix match from zero.
                                if (s.field == F_GAP1) begin
                                    url_pos = 4'd0;
                                end
                                n.field     = F_URL;
                                n.match_pos = url_pos;
                                case (url_cur)
                                    U_IDLE: begin
                                        if (i_byte == CH_SLASH) begin
                                            n.url = U_GOOD;
                                        end else if (lc == prefix_char(3'd0)) begin
                                            n.url       = U_PREFIX;
                                            n.match_pos = 4'd1;
                                        end else begin
                                            n.url = U_BAD;
                                        end
                                    end
                                    U_PREFIX: begin
                                        if (url_pos < PREFIX_LEN
                                            && lc == prefix_char(url_pos[2:0])) begin
                                            n.match_pos = 4'(url_pos + 4'd1);
                                            if (4'(url_pos + 4'd1) == PREFIX_LEN) begin
                                                n.url = U_WAIT_SLASH;
                                            end
                                        end else begin
                                            n.url = U_BAD;
                                        end
                                    end
                                    U_WAIT_SLASH: begin
                                        if (i_byte == CH_SLASH) begin
                                            n.url = U_GOOD;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        F_GAP2: begin
                            if (!sep) begin
                                n.field = F_VERSION;
                                if (i_byte == version_char(3'd0)) begin
                                    n.match_pos = 4'd1;
                                end else begin
                                    n.match_pos = 4'd0;
                                    n.match_ok  = 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (s.match_pos < VERSION_LEN
                                && i_byte == version_char(s.match_pos[2:0])) begin
                                n.match_pos = 4'(s.match_pos + 4'd1);
                            end else begin
                                n.match_ok = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
        o_state = n;
    end

endmodule

### rtl/core/http_get_request_parser.sv
// Top level of the HTTP GET request parser: handshakes, state and result registers.
// Depends on hgrp_pkg and hgrp_step.
//
// Usage:
// The input channel carries one word per byte of the request stream, with a
// conn_start flag that clears the parser before that byte is taken. The output
// channel returns one word for every input word: a verdict (more needed, GET
// complete or bad request) and an in_headers flag set once the request line has
// been accepted. A verdict other than "more needed" is held until conn_start.
// The result of an accepted word is registered and is offered in the cycle after
// it is accepted. Throughput is one word per cycle while the receiver takes each
// result, set by the single pass through the next-state logic between the parser
// state register and the result register. The input is ready whenever the result
// register is empty or is being read in the same cycle, so a stalled receiver
// holds the result and stops the input after one word. Reset clears the parser
// state and empties the result register.
module http_get_request_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hgrp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hgrp_pkg::t_out_word o_out_data
);
    import hgrp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_out_word    r_out_data;
    logic         in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    hgrp_step u_step (
        .i_state      (r_state),
        .i_byte       (i_in_data.data_byte),
        .i_conn_start (i_in_data.conn_start),
        .o_state      (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data.verdict    <= n_state.verdict;
            r_out_data.in_headers <= n_state.in_headers;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
